// ===== hw/rtl/sorted_table_binary_search_assert.svh =====
// Assertion macros shared by the sorted table search modules.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF

`define SBS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sorted table search assertion failed");

`define SBS_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("sorted table search assertion failed");

`else

`define SBS_ASSERT(name, clk, rst, prop)

`define SBS_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== hw/rtl/sbs_pkg.sv =====
package sbs_pkg;

   localparam int DATA_BITS  = 32;
   localparam int SLOT_BITS  = 10;
   localparam int COUNT_BITS = 11;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef struct packed {
      logic                        func;
      logic [SLOT_BITS-1:0]        slot;
      logic signed [DATA_BITS-1:0] word;
   } req_word_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] first_slot;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMPARE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic start;
      logic probe;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic range_open;
   } status_type;

endpackage

// ===== hw/rtl/sbs_ram.sv =====
module sbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sbs_ctrl.sv =====
`include "sorted_table_binary_search_assert.svh"

module sbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sbs_pkg::cmd_type    cmd,
   input  sbs_pkg::status_type status
);

   import sbs_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_func == FUNC_SEARCH)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.range_open) begin
               state_in = ST_COMPARE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_COMPARE: begin
            state_in = ST_CHECK;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_func == FUNC_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.start = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            cmd.probe = status.range_open;
         end
         ST_COMPARE: begin
            cmd.step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SBS_ASSERT(a_compare_follows_probe, clock, reset,
      (state_ff == ST_COMPARE) |-> ($past(state_ff) == ST_CHECK))
   `SBS_ASSERT(a_emit_into_free_register, clock, reset,
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
   `SBS_ASSERT(a_search_starts_probing, clock, reset,
      (req_valid && !req_stall && (req_func == FUNC_SEARCH)) |=> (state_ff == ST_CHECK))

endmodule

// ===== hw/rtl/sbs_datapath.sv =====
`include "sorted_table_binary_search_assert.svh"

module sbs_datapath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sbs_pkg::COUNT_BITS-1:0]      csr_wr_data,
   input  sbs_pkg::req_word_type               req_word,
   input  sbs_pkg::cmd_type                    cmd,
   output sbs_pkg::status_type                 status,
   output sbs_pkg::rsp_word_type               rsp_word
);

   import sbs_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;

   logic [COUNT_BITS-1:0]       count_ff;
   logic [CW-1:0]               n_cap;
   logic signed [DATA_BITS-1:0] key_ff;
   logic [CW-1:0]               lo_ff;
   logic [CW-1:0]               lo_in;
   logic [CW-1:0]               end_ff;
   logic [CW-1:0]               end_in;
   logic [CW:0]                 mid_sum;
   logic [AW-1:0]               mid;
   logic [AW-1:0]               mid_ff;
   logic                        hit_ff;
   logic                        hit_in;
   logic [AW-1:0]               pos_ff;
   logic [AW-1:0]               pos_in;
   rsp_word_type                rsp_word_ff;
   logic                        slot_ok;
   logic                        ram_wr_en;
   logic [DATA_BITS-1:0]        ram_rd_data;
   logic signed [DATA_BITS-1:0] probe_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (32'(count_ff) > 32'(TABLE_DEPTH)) begin
         n_cap = CW'(TABLE_DEPTH);
      end else begin
         n_cap = CW'(count_ff);
      end
   end

   assign slot_ok   = 32'(req_word.slot) < 32'(TABLE_DEPTH);
   assign ram_wr_en = cmd.load_wr && slot_ok;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, end_ff} - (CW+1)'(1);
   assign mid     = mid_sum[AW:1];

   sbs_ram #(
      .WIDTH(DATA_BITS),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(AW'(req_word.slot)),
      .wr_data(req_word.word),
      .rd_en  (cmd.probe),
      .rd_addr(mid),
      .rd_data(ram_rd_data)
   );

   assign probe_word = $signed(ram_rd_data);

   always_comb begin
      lo_in  = lo_ff;
      end_in = end_ff;
      hit_in = hit_ff;
      pos_in = pos_ff;
      if (cmd.start) begin
         lo_in  = '0;
         end_in = n_cap;
         hit_in = 1'b0;
      end else if (cmd.step) begin
         if (probe_word == key_ff) begin
            hit_in = 1'b1;
            pos_in = mid_ff;
            end_in = {1'b0, mid_ff};
         end else if (probe_word < key_ff) begin
            lo_in = {1'b0, mid_ff} + CW'(1);
         end else begin
            end_in = {1'b0, mid_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      end_ff <= end_in;
      hit_ff <= hit_in;
      pos_ff <= pos_in;
      if (cmd.start) begin
         key_ff <= req_word.word;
      end
      if (cmd.probe) begin
         mid_ff <= mid;
      end
      if (cmd.emit) begin
         rsp_word_ff.found      <= hit_ff;
         rsp_word_ff.first_slot <= hit_ff ? SLOT_BITS'(pos_ff) : '0;
      end
   end

   assign status.range_open = lo_ff < end_ff;
   assign rsp_word          = rsp_word_ff;

   `SBS_ASSERT(a_probe_in_open_range, clock, reset,
      cmd.probe |-> (lo_ff < end_ff))
   `SBS_ASSERT(a_range_stays_ordered, clock, reset,
      cmd.step |=> (lo_ff <= end_ff))
   `SBS_ASSERT(a_range_shrinks, clock, reset,
      cmd.step |=> ((end_ff < $past(end_ff)) || (lo_ff > $past(lo_ff))))

endmodule

// ===== hw/rtl/sorted_table_binary_search.sv =====
// Leftmost binary search over a table of signed 32-bit entries kept in ascending order.
// Request words on req_valid/req_stall either load one entry (func 0, at slot) or
// search for a key (func 1). Response words on rsp_valid/rsp_stall carry found and
// the lowest matching slot, which is 0 when the key is absent. Loads give no response.
// csr_wr_en/csr_wr_data set the number of entries searched, from slot 0 upward.
// A load is taken while idle. A search passes through CHECK then COMPARE for each
// midpoint it probes, since the table RAM has a registered read and the compare uses
// its data in the next cycle. A search makes at most floor(log2(count)) + 1 probes,
// then emits its response into the output register, and after that the next request is taken.
// The finished response sits in an output register, so a new request is taken while
// the receiver stalls; a second search then waits to deliver until the register frees.
// Reset clears the entry count to zero and returns the controller to idle with no
// response pending. Table entries are not cleared and must be loaded before use.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sbs_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sbs_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_wr_en,
   input  logic [sbs_pkg::COUNT_BITS-1:0] csr_wr_data
);

   import sbs_pkg::*;

   cmd_type    cmd;
   status_type status;

   sbs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_func (req_word.func),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .status   (status)
   );

   sbs_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_word   (req_word),
      .cmd        (cmd),
      .status     (status),
      .rsp_word   (rsp_word)
   );

endmodule
